>>> rtl/core/bpc_pkg.sv
// bpc_pkg: opcodes, field widths and timing constants for the beeper
// pattern controller. No dependencies.
package bpc_pkg;

  localparam int unsigned OP_W    = 3;
  localparam int unsigned DUR_W   = 17;
  localparam int unsigned PER_W   = 18;
  localparam int unsigned LIMIT_W = 16;

  typedef logic [OP_W-1:0]    opcode_t;
  typedef logic [DUR_W-1:0]   dur_t;
  typedef logic [PER_W-1:0]   period_t;
  typedef logic [LIMIT_W-1:0] limit_t;

  localparam opcode_t OP_TICK  = 3'd0;
  localparam opcode_t OP_ON    = 3'd1;
  localparam opcode_t OP_OFF   = 3'd2;
  localparam opcode_t OP_ONE   = 3'd3;
  localparam opcode_t OP_TIMER = 3'd4;
  localparam opcode_t OP_REP   = 3'd5;

  localparam dur_t    ONE_SHOT_MS = 17'd200;
  localparam dur_t    DUR_MIN     = 17'd20;
  localparam dur_t    DUR_MAX     = 17'd99999;
  localparam period_t START_DELAY = 18'd100;
  localparam dur_t    DEFAULT_ON  = 17'd500;
  localparam dur_t    DEFAULT_OFF = 17'd2000;

endpackage

>>> rtl/core/beeper_pattern_controller.sv
// beeper_pattern_controller: state update for steady, one-shot and periodic
// beeper patterns, one request per cycle while in_stall is low. Depends on bpc_pkg.
//
// Usage:
//   Input channel (in_*): each request is a 1 ms tick or a command (on, off,
//   one-shot, timer, rep) with durations and a repeat limit. A request is
//   taken on a rising edge with in_valid high and in_stall low.
//   Result channel (out_*): one result per request with the speaker level,
//   whether the periodic pattern runs, and an accept/reject status.
//   Latency: the result is valid the cycle after its request is taken; the
//   state update and result register are written at that same edge.
//   Throughput: one request per cycle, set by the single result register;
//   in_stall rises only while a result is held and out_stall is high.
//   Stall: a held result stays put and unchanged until taken; a new request
//   is taken in the same cycle the held result leaves.
//   Reset (rst_n low, synchronous): speaker off, pattern stopped, all counts
//   and stored lengths zero, no result pending.
module beeper_pattern_controller (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  bpc_pkg::opcode_t        in_opcode,
  input  bpc_pkg::dur_t           in_off_time_ms,
  input  bpc_pkg::dur_t           in_on_time_ms,
  input  bpc_pkg::limit_t         in_repeat_limit,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_speaker,
  output logic                    out_pattern_active,
  output logic                    out_status
);
  import bpc_pkg::*;

  logic    speaker_r,  speaker_nxt;
  logic    running_r,  running_nxt;
  period_t period_r,   period_nxt;
  dur_t    silence_r,  silence_nxt;
  dur_t    off_len_r,  off_len_nxt;
  dur_t    on_len_r,   on_len_nxt;
  limit_t  limit_r,    limit_nxt;
  limit_t  count_r,    count_nxt;
  logic    out_valid_r;
  logic    status_r,   status_nxt;

  logic    accept;
  logic    dur_ok;
  logic    fire;
  dur_t    sil_ticked;
  dur_t    fire_on, fire_off;
  limit_t  count_inc;

  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  assign dur_ok = (in_off_time_ms >= DUR_MIN) && (in_off_time_ms <= DUR_MAX) &&
                  (in_on_time_ms >= DUR_MIN) && (in_on_time_ms <= DUR_MAX);

  // tick side: off countdown first, then the period counter
  assign sil_ticked = (silence_r != '0) ? silence_r - 1'b1 : silence_r;
  assign fire       = running_r && (period_r <= period_t'(1));
  assign fire_on    = ((on_len_r == '0) || (off_len_r == '0)) ? DEFAULT_ON  : on_len_r;
  assign fire_off   = ((on_len_r == '0) || (off_len_r == '0)) ? DEFAULT_OFF : off_len_r;
  assign count_inc  = count_r + 1'b1;

  always_comb begin
    speaker_nxt = speaker_r;
    running_nxt = running_r;
    period_nxt  = period_r;
    silence_nxt = silence_r;
    off_len_nxt = off_len_r;
    on_len_nxt  = on_len_r;
    limit_nxt   = limit_r;
    count_nxt   = count_r;
    status_nxt  = 1'b0;
    unique case (in_opcode)
      OP_TICK: begin
        silence_nxt = sil_ticked;
        if ((silence_r != '0) && (sil_ticked == '0)) begin
          speaker_nxt = 1'b0;
        end
        if (running_r) begin
          period_nxt = period_r - 1'b1;
        end
        if (fire) begin
          on_len_nxt  = fire_on;
          off_len_nxt = fire_off;
          speaker_nxt = 1'b1;
          if (sil_ticked == '0) begin
            silence_nxt = fire_on;
          end
          period_nxt = {1'b0, fire_off} + {1'b0, fire_on};
          if (limit_r != '0) begin
            count_nxt = count_inc;
            if (count_inc == limit_r) begin
              running_nxt = 1'b0;
              count_nxt   = '0;
            end
          end
        end
      end
      OP_ON: begin
        running_nxt = 1'b0;
        speaker_nxt = 1'b1;
      end
      OP_OFF: begin
        running_nxt = 1'b0;
        speaker_nxt = 1'b0;
      end
      OP_ONE: begin
        running_nxt = 1'b0;
        speaker_nxt = 1'b1;
        if (silence_r == '0) begin
          silence_nxt = ONE_SHOT_MS;
        end
      end
      OP_TIMER, OP_REP: begin
        if (!dur_ok) begin
          status_nxt = 1'b1;
        end else begin
          off_len_nxt = in_off_time_ms;
          on_len_nxt  = in_on_time_ms;
          if (in_opcode == OP_REP) begin
            limit_nxt = in_repeat_limit;
          end
          if (!running_r) begin
            period_nxt  = START_DELAY;
            running_nxt = 1'b1;
          end
        end
      end
      default: begin
        status_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speaker_r   <= 1'b0;
      running_r   <= 1'b0;
      period_r    <= '0;
      silence_r   <= '0;
      off_len_r   <= '0;
      on_len_r    <= '0;
      limit_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= 1'b0;
    end else begin
      if (accept) begin
        speaker_r <= speaker_nxt;
        running_r <= running_nxt;
        period_r  <= period_nxt;
        silence_r <= silence_nxt;
        off_len_r <= off_len_nxt;
        on_len_r  <= on_len_nxt;
        limit_r   <= limit_nxt;
        count_r   <= count_nxt;
        status_r  <= status_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_speaker        = speaker_r;
  assign out_pattern_active = running_r;
  assign out_status         = status_r;

endmodule

>>> rtl/core/bpc_checker.sv
// bpc_port_checker: port-level assertions for beeper_pattern_controller, bound
// into every instance of that module. Depends on bpc_pkg.
module bpc_port_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input bpc_pkg::opcode_t in_opcode,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_speaker,
  input logic             out_pattern_active,
  input logic             out_status
);
  import bpc_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // held result does not move while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_speaker) &&
      $stable(out_pattern_active) && $stable(out_status))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // off request silences the speaker and stops the periodic pattern
  a_off: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_opcode == OP_OFF |=> out_valid && !out_speaker &&
      !out_pattern_active && !out_status)
    else $error("off request result wrong");

  a_on: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_opcode == OP_ON || in_opcode == OP_ONE) |=>
      out_valid && out_speaker && !out_pattern_active && !out_status)
    else $error("on request result wrong");

  a_bad_op: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !(in_opcode == OP_TICK || in_opcode == OP_ON || in_opcode == OP_OFF ||
      in_opcode == OP_ONE || in_opcode == OP_TIMER || in_opcode == OP_REP) |=>
      out_valid && out_status)
    else $error("unknown opcode not rejected");

endmodule

bind beeper_pattern_controller bpc_port_checker u_bpc_port_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_opcode          (in_opcode),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_speaker        (out_speaker),
  .out_pattern_active (out_pattern_active),
  .out_status         (out_status)
);
